[hw/rtl/kth_pkg.sv]
// Shared types, constants and lookup tables for the keysym to HID keyboard report block.
// No dependencies; imported by kth_report and keysym_to_hid_keyboard_report_top.
`timescale 1ns / 1ps

package kth_pkg;

	localparam int unsigned NUM_SLOTS = 6;

	// Keysyms with a fixed meaning
	localparam logic [15:0] SYM_CAPS       = 16'hFFE5;
	localparam logic [15:0] SYM_NUM        = 16'hFF7F;
	localparam logic [15:0] SYM_UPPER_A    = 16'h0041;
	localparam logic [15:0] SYM_UPPER_Z    = 16'h005A;
	localparam logic [15:0] SYM_LOWER_A    = 16'h0061;
	localparam logic [15:0] SYM_LOWER_Z    = 16'h007A;
	localparam logic [15:0] SYM_KP_DIG_LO  = 16'hFFB0;
	localparam logic [15:0] SYM_KP_DIG_HI  = 16'hFFB9;
	localparam logic [15:0] SYM_KP_DEC     = 16'hFFAE;
	localparam logic [15:0] SYM_KP_NAV_LO  = 16'hFF95;
	localparam logic [15:0] SYM_KP_NAV_HI  = 16'hFF9F;
	localparam logic [7:0]  SYM_SPECIAL_HI = 8'hFF;

	localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
	localparam logic [7:0] ROLLOVER_CODE  = 8'h01;

	// Held keyboard state
	typedef struct packed {
		logic [7:0]                    mods;
		logic [NUM_SLOTS-1:0][7:0]     keys;
	} hold_t;

	// One report, less the end-of-event mark
	typedef struct packed {
		logic [7:0]                    mods;
		logic [NUM_SLOTS-1:0][7:0]     keys;
		logic                          roll;
	} rep_t;

	localparam logic [7:0] SPECIAL_ROM [256] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2A,8'h2B,8'h00,8'h9C,8'h00,8'h58,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h48,8'h47,8'h9A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h93,8'h92,8'h00,8'h00,8'h00,8'h94,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h4A,8'h50,8'h52,8'h4F,8'h51,8'h4B,8'h4E,8'h4D,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h77,8'h46,8'h74,8'h49,8'h00,8'h7A,8'h00,8'h65,8'h7E,8'h78,8'h75,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h53,
		8'h2C,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2B,8'h00,8'h00,8'h00,8'h58,8'h00,8'h00,
		8'h00,8'h3A,8'h3B,8'h3C,8'h3D,8'h5F,8'h5C,8'h60,8'h5E,8'h5A,8'h61,8'h5B,8'h59,8'h00,8'h62,8'h63,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h55,8'h57,8'h00,8'h56,8'h63,8'h54,
		8'h62,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,8'h60,8'h61,8'h00,8'h00,8'h00,8'h67,8'h3A,8'h3B,
		8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h68,8'h69,8'h6A,8'h6B,8'h6C,8'h6D,
		8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h73,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h39,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h4C
	};

	localparam logic [7:0] ASCII_ROM [128] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2A,8'h2B,8'h28,8'h00,8'h00,8'h28,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h2C,8'h1E,8'h34,8'h20,8'h21,8'h22,8'h24,8'h34,8'h26,8'h27,8'h25,8'h2E,8'h36,8'h2D,8'h37,8'h38,
		8'h27,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h33,8'h33,8'h36,8'h2E,8'h37,8'h38,
		8'h1F,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h11,8'h12,
		8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h2F,8'h31,8'h30,8'h23,8'h2D,
		8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h11,8'h12,
		8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h2F,8'h31,8'h30,8'h35,8'h63
	};

	// Keysym to usage code; 0 means unknown
	function automatic logic [7:0] usage_of(input logic [15:0] sym);
		logic [7:0] code;
		code = 8'h00;
		if (sym[15:8] == SYM_SPECIAL_HI) begin
			code = SPECIAL_ROM[sym[7:0]];
		end else if (sym[15:7] == 9'd0) begin
			code = ASCII_ROM[sym[6:0]];
		end
		return code;
	endfunction

	// Modifier keysym to its bit in the modifier byte
	function automatic logic [7:0] modifier_bit(input logic [15:0] sym);
		logic [7:0] mb;
		unique case (sym)
			16'hFFE1: mb = 8'h02;
			16'hFFE2: mb = 8'h20;
			16'hFFE3: mb = 8'h01;
			16'hFFE4: mb = 8'h10;
			16'hFFE7, 16'hFFE9: mb = 8'h04;
			16'hFFE8, 16'hFFEA: mb = 8'h40;
			16'hFFEB: mb = 8'h08;
			16'hFFEC: mb = 8'h80;
			default: mb = 8'h00;
		endcase
		return mb;
	endfunction

endpackage

[hw/rtl/keysym_to_hid_keyboard_report_top.sv]
// Keysym to USB HID boot keyboard report converter, six-key rollover: top level.
// Depends on kth_pkg and kth_report.
//
//   channel | direction | tdata                        | tuser                     | tlast
//   s_*     | in        | keysym[15:0]                 | key_down, caps, num lit   | -
//   m_*     | out       | modifiers, slot_0 .. slot_5  | rollover_error            | last_report
//
// An event issues one report when no lock pair is inserted and three reports when a caps
// lock or num lock press/release pair goes first; one report leaves per cycle through the
// output register unless m_tready stalls it, the held-state register being updated with
// each report. A new event is taken in the cycle its predecessor issues its final report.
// arst_n clears the held modifiers and keys and empties both stages.
// A stall on m_tready holds the current report and freezes the event in progress.
`timescale 1ns / 1ps

module keysym_to_hid_keyboard_report_top import kth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] keysym
	input  logic [2:0]  s_tuser,   // [0] key_down, [1] caps_lock_lit, [2] num_lock_lit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] modifiers, then slot_0 .. slot_5 a byte each
	output logic [0:0]  m_tuser,   // [0] rollover_error
	output logic        m_tlast    // last_report
);

	typedef enum logic [2:0] {
		PH_START   = 3'b001,
		PH_RELEASE = 3'b010,
		PH_MAIN    = 3'b100
	} phase_t;

	// Event stage
	logic        valid_s1;
	logic [15:0] sym_s1;
	logic        down_s1;
	logic        caps_s1;
	logic        num_s1;
	phase_t      phase_s1;

	// Held state and output register
	hold_t held_q;
	logic  m_valid_q;
	rep_t  m_rep_q;
	logic  m_last_q;

	logic        out_free;
	logic        fire;
	logic        shift;
	logic        need_lock;
	logic [15:0] lock_sym;
	logic        issue_main;
	logic [15:0] rep_sym;
	logic        rep_down;
	rep_t        rep;
	hold_t       held_next;

	// Lock pair decision against the current held state
	always_comb begin
		logic upper;
		logic lower;
		logic kp_dig;
		logic kp_nav;
		upper  = down_s1 && sym_s1 >= SYM_UPPER_A && sym_s1 <= SYM_UPPER_Z;
		lower  = down_s1 && sym_s1 >= SYM_LOWER_A && sym_s1 <= SYM_LOWER_Z;
		kp_dig = (sym_s1 >= SYM_KP_DIG_LO && sym_s1 <= SYM_KP_DIG_HI) || sym_s1 == SYM_KP_DEC;
		kp_nav = sym_s1 >= SYM_KP_NAV_LO && sym_s1 <= SYM_KP_NAV_HI;
		shift  = (held_q.mods & MOD_SHIFT_MASK) != 8'h00;
		priority if (kp_dig) begin
			need_lock = !num_s1;
			lock_sym  = SYM_NUM;
		end else if (kp_nav) begin
			need_lock = num_s1;
			lock_sym  = SYM_NUM;
		end else if (upper) begin
			need_lock = shift == caps_s1;
			lock_sym  = SYM_CAPS;
		end else if (lower) begin
			need_lock = shift != caps_s1;
			lock_sym  = SYM_CAPS;
		end else begin
			need_lock = 1'b0;
			lock_sym  = SYM_CAPS;
		end
	end

	// Which report this cycle builds
	always_comb begin
		unique case (phase_s1)
			PH_START: begin
				issue_main = !need_lock;
				rep_sym    = need_lock ? lock_sym : sym_s1;
				rep_down   = need_lock ? 1'b1 : down_s1;
			end
			PH_RELEASE: begin
				issue_main = 1'b0;
				rep_sym    = lock_sym;
				rep_down   = 1'b0;
			end
			PH_MAIN: begin
				issue_main = 1'b1;
				rep_sym    = sym_s1;
				rep_down   = down_s1;
			end
			default: begin
				issue_main = 1'b1;
				rep_sym    = sym_s1;
				rep_down   = down_s1;
			end
		endcase
	end

	kth_report u_report (
		.sym       (rep_sym),
		.down      (rep_down),
		.held      (held_q),
		.rep       (rep),
		.held_next (held_next)
	);

	assign out_free = !m_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || (fire && issue_main);

	// Event stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= PH_START;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
			phase_s1 <= PH_START;
		end else if (fire) begin
			if (issue_main) begin
				valid_s1 <= 1'b0;
				phase_s1 <= PH_START;
			end else if (phase_s1 == PH_START) begin
				phase_s1 <= PH_RELEASE;
			end else begin
				phase_s1 <= PH_MAIN;
			end
		end
	end

	// Event payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sym_s1  <= s_tdata;
			down_s1 <= s_tuser[0];
			caps_s1 <= s_tuser[1];
			num_s1  <= s_tuser[2];
		end
	end

	// Held state follows every issued report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (fire) begin
			held_q <= held_next;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_rep_q  <= rep;
			m_last_q <= issue_main;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {m_rep_q.keys, m_rep_q.mods};
	assign m_tuser[0] = m_rep_q.roll;
	assign m_tlast    = m_last_q;

endmodule

[hw/rtl/kth_report.sv]
// Report builder: one keysym press or release against the held state gives one report
// and the next held state. Combinational. Depends on kth_pkg.
`timescale 1ns / 1ps

module kth_report import kth_pkg::*; (
	input  logic [15:0] sym,
	input  logic        down,
	input  hold_t       held,
	output rep_t        rep,
	output hold_t       held_next
);

	logic [7:0]                usage;
	logic [7:0]                mb;
	logic [7:0]                mods_n;
	logic [NUM_SLOTS-1:0][7:0] rel_keys;
	logic [NUM_SLOTS-1:0][7:0] press_keys;
	logic                      full;

	assign usage = usage_of(sym);
	assign mb    = modifier_bit(sym);

	// Modifier byte update happens for every report
	assign mods_n = down ? (held.mods | mb) : (held.mods & ~mb);

	// Release: drop every slot holding the code and pack toward slot 0
	always_comb begin
		logic [2:0] cnt;
		cnt = 3'd0;
		rel_keys = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (held.keys[k] != usage) begin
				rel_keys[cnt] = held.keys[k];
				cnt = cnt + 3'd1;
			end
		end
	end

	// Press: copy the filled prefix, append at the first free slot unless already held
	always_comb begin
		logic run;
		logic dup;
		run = 1'b1;
		dup = 1'b0;
		press_keys = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (run && held.keys[k] != 8'h00) begin
				press_keys[k] = held.keys[k];
				if (held.keys[k] == usage) begin
					dup = 1'b1;
				end
			end else if (run) begin
				press_keys[k] = dup ? 8'h00 : usage;
				run = 1'b0;
			end
		end
		full = run;
	end

	// Pick the outcome
	always_comb begin
		rep.mods       = mods_n;
		rep.roll       = 1'b0;
		held_next.mods = mods_n;
		priority if (usage == 8'h00) begin
			rep.keys       = held.keys;
			held_next.keys = held.keys;
		end else if (!down) begin
			rep.keys       = rel_keys;
			held_next.keys = rel_keys;
		end else if (!full) begin
			rep.keys       = press_keys;
			held_next.keys = press_keys;
		end else begin
			rep.keys       = {NUM_SLOTS{ROLLOVER_CODE}};
			rep.roll       = 1'b1;
			held_next.keys = held.keys;
		end
	end

endmodule

[dv/tb.sv]
// Self-checking testbench for keysym_to_hid_keyboard_report_top: a directed table of key events,
// then random events, each report checked against the in-bench predictor or a typed row's entry.
// Depends only on the RTL under hw/rtl (kth_pkg, kth_report, keysym_to_hid_keyboard_report_top).
`timescale 1ns / 1ps

module tb;

	// Keysyms with a fixed meaning
	localparam logic [15:0] KS_SHIFT_L    = 16'hFFE1;
	localparam logic [15:0] KS_SHIFT_R    = 16'hFFE2;
	localparam logic [15:0] KS_CONTROL_L  = 16'hFFE3;
	localparam logic [15:0] KS_CONTROL_R  = 16'hFFE4;
	localparam logic [15:0] KS_CAPS_LOCK  = 16'hFFE5;
	localparam logic [15:0] KS_META_L     = 16'hFFE7;
	localparam logic [15:0] KS_META_R     = 16'hFFE8;
	localparam logic [15:0] KS_ALT_L      = 16'hFFE9;
	localparam logic [15:0] KS_ALT_R      = 16'hFFEA;
	localparam logic [15:0] KS_SUPER_L    = 16'hFFEB;
	localparam logic [15:0] KS_SUPER_R    = 16'hFFEC;
	localparam logic [15:0] KS_NUM_LOCK   = 16'hFF7F;
	localparam logic [15:0] KS_UPPER_A    = 16'h0041;
	localparam logic [15:0] KS_UPPER_Z    = 16'h005A;
	localparam logic [15:0] KS_LOWER_A    = 16'h0061;
	localparam logic [15:0] KS_LOWER_Z    = 16'h007A;
	localparam logic [15:0] KS_KP_0       = 16'hFFB0;
	localparam logic [15:0] KS_KP_9       = 16'hFFB9;
	localparam logic [15:0] KS_KP_DECIMAL = 16'hFFAE;
	localparam logic [15:0] KS_KP_HOME    = 16'hFF95;
	localparam logic [15:0] KS_KP_DELETE  = 16'hFF9F;

	// Modifier byte bits
	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_LALT   = 8'h04;
	localparam logic [7:0] MOD_LGUI   = 8'h08;
	localparam logic [7:0] MOD_RCTRL  = 8'h10;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;
	localparam logic [7:0] MOD_RGUI   = 8'h80;
	localparam logic [7:0] ROLL_FILL  = 8'h01;

	localparam int RANDOM_EVENTS = 155;
	localparam int PAUSE_AT      = 77;
	localparam int MAX_WAIT      = 17;
	localparam int CYCLE_LIMIT   = 200000;

	// Usage tables, entry 0 in the top bits
	localparam logic [0:255][7:0] SPECIAL_USAGE = {
		128'h00000000000000002A2B009C00580000, 128'h00000048479A00000000002900000000,
		128'h00000000009392000000940000000000, 128'h00000000000000000000000000000000,
		128'h00000000000000000000000000000000, 128'h4A50524F514B4E4D0000000000000000,
		128'h77467449007A00657E78750000000000, 128'h00000000000000000000000000000053,
		128'h2C00000000000000002B000000580000, 128'h003A3B3C3D5F5C605E5A615B59006263,
		128'h00000000000000000000555700566354, 128'h62595A5B5C5D5E5F6061000000673A3B,
		128'h3C3D3E3F40414243444568696A6B6C6D, 128'h6E6F7071727300000000000000000000,
		128'h00000000003900000000000000000000, 128'h0000000000000000000000000000004C
	};
	localparam logic [0:127][7:0] ASCII_USAGE = {
		128'h00000000000000002A2B280000280000, 128'h00000000000000000000000000000000,
		128'h2C1E3420212224342627252E362D3738, 128'h271E1F202122232425263333362E3738,
		128'h1F0405060708090A0B0C0D0E0F101112, 128'h131415161718191A1B1C1D2F3130232D,
		128'h350405060708090A0B0C0D0E0F101112, 128'h131415161718191A1B1C1D2F31303563
	};

	typedef struct packed {
		logic [5:0][7:0] slots;
		logic [7:0]      mods;
		logic            roll;
		logic            last;
	} report_t;

	typedef struct packed {
		logic [15:0]     sym;
		logic            down;
		logic            caps;
		logic            num;
		logic            typed;
		logic [7:0]      mods;
		logic [5:0][7:0] slots;
		logic            roll;
	} key_step_t;

	// Directed events; typed rows carry the final report
	localparam int N_STEPS = 25;
	localparam key_step_t KEY_STEPS [N_STEPS] = '{
		'{16'h1234,      1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 48'h0,      1'b0},
		'{16'hFFFF,      1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 48'h4C,     1'b0},
		'{16'h0000,      1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 48'h4C,     1'b0},
		'{KS_SHIFT_L,    1'b1, 1'b0, 1'b0, 1'b1, 8'h02, 48'h4C,     1'b0},
		'{KS_UPPER_A,    1'b1, 1'b0, 1'b0, 1'b1, 8'h02, 48'h044C,   1'b0},
		'{KS_SHIFT_L,    1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 48'h044C,   1'b0},
		'{KS_LOWER_A,    1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_UPPER_Z,    1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'hFFB5,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_KP_HOME,    1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_KP_DECIMAL, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'h0078,      1'b1, 1'b0, 1'b0, 1'b1, 8'h00, {6{8'h01}}, 1'b1},
		'{KS_UPPER_A,    1'b1, 1'b1, 1'b0, 1'b1, 8'h00, {6{8'h01}}, 1'b1},
		'{KS_CONTROL_R,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_LOWER_A,    1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'hFFB5,      1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_KP_HOME,    1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'h00FF,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'h0080,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'hFF00,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'hFEFF,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{16'h007F,      1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_SUPER_R,    1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_CAPS_LOCK,  1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0},
		'{KS_CONTROL_R,  1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 48'h0,      1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	// Predicted keyboard state and the reports still to come
	logic [7:0]      hid_mods;
	logic [5:0][7:0] hid_keys;
	report_t         awaited_reports[$];
	logic            step_typed = 1'b0;
	report_t         step_report;
	logic [15:0]     pressed_syms[$];
	int              error_count = 0;
	int              cycle_count = 0;
	int              src_burst = 0;
	int              snk_burst = 0;

	keysym_to_hid_keyboard_report_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] usage_code(input logic [15:0] sym);
		if (sym[15:8] == 8'hFF)
			return SPECIAL_USAGE[sym[7:0]];
		if (sym < 16'd128)
			return ASCII_USAGE[sym[6:0]];
		return 8'h00;
	endfunction

	function automatic logic [7:0] mod_mask(input logic [15:0] sym);
		case (sym)
			KS_SHIFT_L:          return MOD_LSHIFT;
			KS_SHIFT_R:          return MOD_RSHIFT;
			KS_CONTROL_L:        return MOD_LCTRL;
			KS_CONTROL_R:        return MOD_RCTRL;
			KS_META_L, KS_ALT_L: return MOD_LALT;
			KS_META_R, KS_ALT_R: return MOD_RALT;
			KS_SUPER_L:          return MOD_LGUI;
			KS_SUPER_R:          return MOD_RGUI;
			default:             return 8'h00;
		endcase
	endfunction

	// One report for one keysym; updates the held state
	function automatic report_t key_report(input logic [15:0] sym, input logic down,
			input logic last);
		report_t         rep;
		logic [7:0]      code;
		logic [5:0][7:0] keys;
		int              fill;
		int              free;
		logic            dup;
		code = usage_code(sym);
		hid_mods = down ? (hid_mods | mod_mask(sym)) : (hid_mods & ~mod_mask(sym));
		rep = '0;
		keys = '0;
		if (code == 8'h00) begin
			keys = hid_keys;
		end else if (!down) begin
			// drop every match and close the gaps
			fill = 0;
			for (int i = 0; i < 6; i++) begin
				if (hid_keys[i] != code) begin
					keys[fill] = hid_keys[i];
					fill++;
				end
			end
			hid_keys = keys;
		end else begin
			free = 6;
			dup = 1'b0;
			for (int i = 5; i >= 0; i--)
				if (hid_keys[i] == 8'h00)
					free = i;
			for (int i = 0; i < 6; i++)
				if (i < free && hid_keys[i] == code)
					dup = 1'b1;
			if (free < 6) begin
				keys = hid_keys;
				if (!dup)
					keys[free] = code;
				hid_keys = keys;
			end else begin
				rep.roll = 1'b1;
				keys = {6{ROLL_FILL}};
			end
		end
		rep.mods = hid_mods;
		rep.slots = keys;
		rep.last = last;
		return rep;
	endfunction

	// Lock pair (if any) then the event's own report
	task automatic queue_event_reports(input logic [15:0] sym, input logic down,
			input logic caps, input logic num);
		logic        shift;
		logic [15:0] lock;
		shift = (hid_mods & (MOD_LSHIFT | MOD_RSHIFT)) != 8'h00;
		lock = '0;
		if (down && sym >= KS_UPPER_A && sym <= KS_UPPER_Z) begin
			if (shift == caps)
				lock = KS_CAPS_LOCK;
		end else if (down && sym >= KS_LOWER_A && sym <= KS_LOWER_Z) begin
			if (shift != caps)
				lock = KS_CAPS_LOCK;
		end
		if ((sym >= KS_KP_0 && sym <= KS_KP_9) || sym == KS_KP_DECIMAL) begin
			if (!num)
				lock = KS_NUM_LOCK;
		end else if (sym >= KS_KP_HOME && sym <= KS_KP_DELETE) begin
			if (num)
				lock = KS_NUM_LOCK;
		end
		if (lock != '0) begin
			awaited_reports.push_back(key_report(lock, 1'b1, 1'b0));
			awaited_reports.push_back(key_report(lock, 1'b0, 1'b0));
		end
		awaited_reports.push_back(key_report(sym, down, 1'b1));
	endtask

	task automatic check_report();
		report_t want;
		if (awaited_reports.size() == 0) begin
			$display("%0t: unexpected report: expected none, actual %h %h %b", $time,
				m_tdata, m_tuser, m_tlast);
			error_count++;
		end else begin
			want = awaited_reports.pop_front();
			if (m_tdata[7:0] !== want.mods) begin
				$display("%0t: modifiers: expected %h, actual %h", $time, want.mods,
					m_tdata[7:0]);
				error_count++;
			end
			for (int i = 0; i < 6; i++) begin
				if (m_tdata[8*i+8 +: 8] !== want.slots[i]) begin
					$display("%0t: slot_%0d: expected %h, actual %h", $time, i,
						want.slots[i], m_tdata[8*i+8 +: 8]);
					error_count++;
				end
			end
			if (m_tuser[0] !== want.roll) begin
				$display("%0t: rollover_error: expected %b, actual %b", $time, want.roll,
					m_tuser[0]);
				error_count++;
			end
			if (m_tlast !== want.last) begin
				$display("%0t: last_report: expected %b, actual %b", $time, want.last,
					m_tlast);
				error_count++;
			end
		end
	endtask

	// Both handshakes sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				queue_event_reports(s_tdata, s_tuser[0], s_tuser[1], s_tuser[2]);
				if (step_typed) begin
					void'(awaited_reports.pop_back());
					awaited_reports.push_back(step_report);
				end
			end
			if (m_tvalid && m_tready)
				check_report();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("keysym_to_hid_keyboard_report_top verification failed");
			$finish;
		end
	end

	// Wait length per beat, with runs of back-to-back beats
	function automatic int draw_wait(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(5, 20);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic send_key(input logic [15:0] sym, input logic down, input logic caps,
			input logic num, input logic typed, input report_t typed_rep);
		int gap;
		gap = draw_wait(src_burst);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = sym;
		s_tuser = {num, caps, down};
		step_typed = typed;
		step_report = typed_rep;
		do
			@(posedge clk);
		while (!s_tready);
		if (down) begin
			pressed_syms.push_back(sym);
			if (pressed_syms.size() > 12)
				void'(pressed_syms.pop_front());
		end
	endtask

	// Random keysym, weighted toward keys that do something
	function automatic logic [15:0] pick_sym();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 1) ? 16'(KS_UPPER_A + $urandom_range(0, 25))
				: 16'(KS_LOWER_A + $urandom_range(0, 25));
			2: begin
				case ($urandom_range(0, 2))
					0:       return 16'(KS_KP_0 + $urandom_range(0, 9));
					1:       return KS_KP_DECIMAL;
					default: return 16'(KS_KP_HOME + $urandom_range(0, 10));
				endcase
			end
			3: begin
				case ($urandom_range(0, 9))
					0:       return KS_SHIFT_L;
					1:       return KS_SHIFT_R;
					2:       return KS_CONTROL_L;
					3:       return KS_CONTROL_R;
					4:       return KS_META_L;
					5:       return KS_META_R;
					6:       return KS_ALT_L;
					7:       return KS_ALT_R;
					8:       return KS_SUPER_L;
					default: return KS_SUPER_R;
				endcase
			end
			4, 5: return 16'($urandom_range(0, 127));
			6: return 16'($urandom_range(128, 255));
			7, 8: return {8'hFF, 8'($urandom_range(0, 255))};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Receiver with random stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(snk_burst);
			repeat (stall) begin
				@(negedge clk);
				m_tready = 1'b0;
			end
			@(negedge clk);
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// Stimulus
	initial begin
		logic [15:0] sym;
		logic        down;
		int          idx;
		report_t     rep;
		hid_mods = '0;
		hid_keys = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int n = 0; n < N_STEPS; n++) begin
			rep.slots = KEY_STEPS[n].slots;
			rep.mods = KEY_STEPS[n].mods;
			rep.roll = KEY_STEPS[n].roll;
			rep.last = 1'b1;
			send_key(KEY_STEPS[n].sym, KEY_STEPS[n].down, KEY_STEPS[n].caps,
				KEY_STEPS[n].num, KEY_STEPS[n].typed, rep);
		end

		// random key traffic: presses, releases of held keys, stray releases
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n == PAUSE_AT) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				while (awaited_reports.size() != 0)
					@(posedge clk);
			end
			if (pressed_syms.size() != 0 && $urandom_range(0, 99) < 45) begin
				idx = $urandom_range(0, pressed_syms.size() - 1);
				sym = pressed_syms[idx];
				pressed_syms.delete(idx);
				down = 1'b0;
			end else begin
				sym = pick_sym();
				down = $urandom_range(0, 99) < 85;
			end
			send_key(sym, down, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("keysym_to_hid_keyboard_report_top verification clean");
		else
			$display("keysym_to_hid_keyboard_report_top verification failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/kth_pkg.sv
hw/rtl/kth_report.sv
hw/rtl/keysym_to_hid_keyboard_report_top.sv
dv/tb.sv
